// ===== hdl/bbvp_pkg.sv =====
package bbvp_pkg;

  // Widest block address that the NUM_BLOCKS range (1 to 63) can need.
  localparam int BLK_ADDR_W  = 6;
  localparam int CNT_W       = 32;
  localparam int STAMP_W     = 48;
  localparam int ENTRY_W     = CNT_W + STAMP_W;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 48;
  localparam int DEF_NUM_BLOCKS = 32;
  localparam logic [STAMP_W-1:0] LIMIT_RESET = 48'd100000000;

  localparam logic OP_BLOCK     = 1'b0;
  localparam logic OP_END       = 1'b1;
  localparam logic KIND_ENTRY   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 8'd1;

  typedef struct packed {
    logic        operation;
    logic [15:0] block_instructions;
    logic [4:0]  block_index;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] region_number;
    logic [4:0]  entry_block;
    logic [31:0] exec_count;
    logic [47:0] last_stamp;
    logic [47:0] region_instructions;
    logic [47:0] total_instructions;
    logic        last;
  } out_item_t;

  // Control from the sequencer to the block store.
  typedef struct packed {
    logic                  rd_en;
    logic [BLK_ADDR_W-1:0] rd_addr;
    logic                  wr_en;
    logic [BLK_ADDR_W-1:0] wr_addr;
    logic                  clr;
  } store_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_SCAN,
    ST_TAIL,
    ST_SUMMARY
  } bbvp_state_t;

endpackage

// ===== hdl/bbvp_store.sv =====
module bbvp_store #(
  parameter int NUM_BLOCKS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bbvp_pkg::store_req_t        req,
  input  logic [bbvp_pkg::ENTRY_W-1:0] wr_data,
  output logic [bbvp_pkg::ENTRY_W-1:0] rd_data,
  output logic                        rd_vld
);
  import bbvp_pkg::*;

  localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

  logic [ENTRY_W-1:0]    mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] valid_r;
  logic [ENTRY_W-1:0]    rd_data_r;
  logic                  rd_vld_r;

  // Entry payload: count in the upper bits, stamp below.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr[AW-1:0]];
    end
  end

  // An entry without its valid bit reads as zero count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.rd_en) begin
        rd_vld_r <= valid_r[req.rd_addr[AW-1:0]];
      end
      if (req.clr) begin
        valid_r <= '0;
      end else if (req.wr_en) begin
        valid_r[req.wr_addr[AW-1:0]] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_data_r;
  assign rd_vld  = rd_vld_r;

endmodule

// ===== hdl/basic_block_vector_profiler_top.sv =====
// Block events are taken one per cycle when idle; each entry is written the next cycle.
// A region close (limit passed or end of interest) keeps busy high through
// a drain state, one store read per block, a tail state and the summary
// state; the summary record is registered out of the summary state.
// Synchronous active-low reset clears counts, stamps and totals, resets registers.
// Results are strobed for one cycle each; the receiver cannot stall them.
module basic_block_vector_profiler_top #(
  parameter int NUM_BLOCKS = bbvp_pkg::DEF_NUM_BLOCKS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  bbvp_pkg::in_item_t              in_data,
  output logic                            out_strobe,
  output bbvp_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bbvp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bbvp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bbvp_pkg::*;

  localparam logic [BLK_ADDR_W-1:0] NB      = BLK_ADDR_W'(NUM_BLOCKS);
  localparam logic [BLK_ADDR_W-1:0] LAST_BLK = BLK_ADDR_W'(NUM_BLOCKS - 1);

  // The controller walks the regions: idle while events stream in, then a
  // drain cycle so the last event's write lands, a scan of the block store,
  // a tail cycle for the final read and the summary.
  bbvp_state_t state_r, state_nxt;

  // Configuration registers.
  logic               enable_r, enable_nxt;
  logic [STAMP_W-1:0] limit_r, limit_nxt;

  // Region-wide counters.
  logic [STAMP_W-1:0] rc_r, rc_nxt;
  logic [STAMP_W-1:0] gt_r, gt_nxt;
  logic [31:0]        region_idx_r, region_idx_nxt;
  logic               close_last_r, close_last_nxt;

  // Second stage of a block event: the store read has returned, so the new
  // count is formed and written back with the stamp taken at the transfer.
  logic                  s1_act_r, s1_act_nxt;
  logic [BLK_ADDR_W-1:0] s1_idx_r, s1_idx_nxt;
  logic [STAMP_W-1:0]    s1_stamp_r, s1_stamp_nxt;
  logic                  s1_fwd_r, s1_fwd_nxt;
  logic [CNT_W-1:0]      fwd_cnt_r;

  // Scan address and the block whose data returns this cycle.
  logic [BLK_ADDR_W-1:0] scan_addr_r, scan_addr_nxt;
  logic                  scan_d_r, scan_d_nxt;
  logic [BLK_ADDR_W-1:0] scan_blk_r, scan_blk_nxt;

  logic      out_strobe_r, out_strobe_nxt;
  out_item_t out_data_r, out_data_nxt;

  store_req_t         req;
  logic [ENTRY_W-1:0] wr_data;
  logic [ENTRY_W-1:0] rd_data;
  logic               rd_vld;

  logic                  accept;
  logic                  ev_hit;
  logic [BLK_ADDR_W-1:0] in_idx;
  logic [STAMP_W:0]      rc_sum;
  logic [STAMP_W-1:0]    rc_new;
  logic [STAMP_W:0]      gt_sum;
  logic [STAMP_W-1:0]    gt_new;
  logic [CNT_W-1:0]      cnt_base;
  logic [CNT_W-1:0]      cnt_new;

  bbvp_store #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .wr_data (wr_data),
    .rd_data (rd_data),
    .rd_vld  (rd_vld)
  );

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign in_idx    = BLK_ADDR_W'(in_data.block_index);

  // Only an enabled event for a block in range touches any state.
  assign ev_hit = accept && (in_data.operation == OP_BLOCK) && enable_r && (in_idx < NB);

  // Saturating region count after this event.
  assign rc_sum = {1'b0, rc_r} + (STAMP_W+1)'(in_data.block_instructions);
  assign rc_new = rc_sum[STAMP_W] ? '1 : rc_sum[STAMP_W-1:0];

  assign gt_sum = {1'b0, gt_r} + {1'b0, rc_r};
  assign gt_new = gt_sum[STAMP_W] ? '1 : gt_sum[STAMP_W-1:0];

  // A back-to-back event on the same block read the store before the
  // previous write landed, so it takes the count from the forwarding register.
  assign cnt_base = s1_fwd_r ? fwd_cnt_r : (rd_vld ? rd_data[ENTRY_W-1:STAMP_W] : '0);
  assign cnt_new  = (cnt_base == '1) ? cnt_base : cnt_base + CNT_W'(1);
  assign wr_data  = {cnt_new, s1_stamp_r};

  always_comb begin
    state_nxt      = state_r;
    enable_nxt     = enable_r;
    limit_nxt      = limit_r;
    rc_nxt         = rc_r;
    gt_nxt         = gt_r;
    region_idx_nxt = region_idx_r;
    close_last_nxt = close_last_r;
    s1_act_nxt     = 1'b0;
    s1_idx_nxt     = s1_idx_r;
    s1_stamp_nxt   = s1_stamp_r;
    s1_fwd_nxt     = 1'b0;
    scan_addr_nxt  = scan_addr_r;
    scan_d_nxt     = 1'b0;
    scan_blk_nxt   = scan_addr_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;

    req.rd_en   = 1'b0;
    req.rd_addr = in_idx;
    req.wr_en   = s1_act_r;
    req.wr_addr = s1_idx_r;
    req.clr     = 1'b0;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ENABLE: enable_nxt = cfg_data[0];
        CFG_LIMIT:  limit_nxt  = cfg_data;
        default:    ;
      endcase
    end

    // A scan read returns: a block that ran in this region gives an entry.
    if (scan_d_r && rd_vld) begin
      out_strobe_nxt                   = 1'b1;
      out_data_nxt.kind                = KIND_ENTRY;
      out_data_nxt.region_number       = region_idx_r;
      out_data_nxt.entry_block         = scan_blk_r[4:0];
      out_data_nxt.exec_count          = rd_data[ENTRY_W-1:STAMP_W];
      out_data_nxt.last_stamp          = rd_data[STAMP_W-1:0];
      out_data_nxt.region_instructions = '0;
      out_data_nxt.total_instructions  = '0;
      out_data_nxt.last                = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_data.operation == OP_END)) begin
          enable_nxt     = 1'b0;
          close_last_nxt = 1'b1;
          state_nxt      = ST_DRAIN;
        end else if (ev_hit) begin
          req.rd_en    = 1'b1;
          rc_nxt       = rc_new;
          s1_act_nxt   = 1'b1;
          s1_idx_nxt   = in_idx;
          s1_stamp_nxt = rc_new;
          s1_fwd_nxt   = s1_act_r && (s1_idx_r == in_idx);
          if (rc_new > limit_r) begin
            close_last_nxt = 1'b0;
            state_nxt      = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        scan_addr_nxt = '0;
        state_nxt     = ST_SCAN;
      end
      ST_SCAN: begin
        req.rd_en     = 1'b1;
        req.rd_addr   = scan_addr_r;
        scan_d_nxt    = 1'b1;
        scan_addr_nxt = scan_addr_r + BLK_ADDR_W'(1);
        if (scan_addr_r == LAST_BLK) begin
          state_nxt = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_nxt = ST_SUMMARY;
      end
      ST_SUMMARY: begin
        out_strobe_nxt                   = 1'b1;
        out_data_nxt.kind                = KIND_SUMMARY;
        out_data_nxt.region_number       = region_idx_r;
        out_data_nxt.entry_block         = '0;
        out_data_nxt.exec_count          = '0;
        out_data_nxt.last_stamp          = '0;
        out_data_nxt.region_instructions = rc_r;
        out_data_nxt.total_instructions  = gt_new;
        out_data_nxt.last                = close_last_r;
        gt_nxt         = gt_new;
        rc_nxt         = '0;
        region_idx_nxt = region_idx_r + 32'd1;
        req.clr        = 1'b1;
        state_nxt      = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      enable_r     <= 1'b0;
      limit_r      <= LIMIT_RESET;
      rc_r         <= '0;
      gt_r         <= '0;
      region_idx_r <= '0;
      close_last_r <= 1'b0;
      s1_act_r     <= 1'b0;
      s1_fwd_r     <= 1'b0;
      scan_addr_r  <= '0;
      scan_d_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      enable_r     <= enable_nxt;
      limit_r      <= limit_nxt;
      rc_r         <= rc_nxt;
      gt_r         <= gt_nxt;
      region_idx_r <= region_idx_nxt;
      close_last_r <= close_last_nxt;
      s1_act_r     <= s1_act_nxt;
      s1_fwd_r     <= s1_fwd_nxt;
      scan_addr_r  <= scan_addr_nxt;
      scan_d_r     <= scan_d_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r   <= s1_idx_nxt;
    s1_stamp_r <= s1_stamp_nxt;
    fwd_cnt_r  <= cnt_new;
    scan_blk_r <= scan_blk_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

`ifndef SYNTHESIS
  // A summary leaves only from the summary state.
  a_summary_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_data_r.kind == KIND_SUMMARY) |-> $past(state_r == ST_SUMMARY))
    else $error("summary transfer without summary state");

  // Event write-back never overlaps the scan.
  a_wb_window: assert property (@(posedge clk) disable iff (!rst_n)
    s1_act_r |-> (state_r == ST_IDLE || state_r == ST_DRAIN))
    else $error("store write-back during scan");

  // The region counter is cleared once a region closes.
  a_rc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUMMARY) |=> (rc_r == '0 && state_r == ST_IDLE))
    else $error("region counter not cleared after close");

  // End of interest always starts a close and disables profiling.
  a_end_close: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.operation == OP_END) |=> (state_r == ST_DRAIN && !enable_r))
    else $error("end of interest did not close region");
`endif

endmodule

// ===== tb/tb_basic_block_vector_profiler_top.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the basic block vector profiler.
// Each event that the block takes runs through a predictor, which computes
// the per-block entries and the region summary that the block should strobe.
// A monitor checks every strobed record against the oldest expected one.
module tb_basic_block_vector_profiler_top;
  import bbvp_pkg::*;

  // The bench runs the block at its default size, so every block index that
  // the 5-bit field can carry maps onto a real entry.
  localparam int NB = DEF_NUM_BLOCKS;

  // A region close keeps the block busy through its drain, scan, tail and
  // summary states. Counting events give no record but still write the store
  // in the cycle after the transfer, so the bench lets HOLD_OFF quiet cycles
  // pass before it touches a register or finishes.
  localparam int HOLD_OFF     = NB + 8;
  localparam int MAX_GAP      = 18;
  localparam int ITEMS_WANTED = 200;
  localparam int LIMIT_CYCLES = 400000;
  localparam int REPORT_MAX   = 10;

  // Register indexes that the block does not decode; writes to them must
  // leave both registers alone.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = CFG_LIMIT + 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_IDX   = '1;
  localparam logic [STAMP_W-1:0]   LIMIT_MAX     = '1;

  typedef enum logic [1:0] {
    ACT_ITEM,
    ACT_CFG,
    ACT_HOLD
  } act_kind_e;

  typedef enum logic [2:0] {
    D_FETCH,
    D_GAP,
    D_ITEM,
    D_DRAIN,
    D_HOLD,
    D_CFG,
    D_DONE
  } drv_state_e;

  // One step of the stimulus: an event to transfer after a gap, a register
  // write, or a pause until the block has gone quiet.
  typedef struct {
    act_kind_e              kind;
    in_item_t               item;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    int unsigned            gap;
  } action_t;

  // Clock, reset and the block's inputs, all known from time zero.
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  in_item_t              in_data   = '0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  busy;
  logic                  out_strobe;
  out_item_t             out_data;
  logic                  cfg_ready;

  basic_block_vector_profiler_top #(
    .NUM_BLOCKS (NB)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stimulus still to be sent and records still to be seen.
  action_t   pending_ops[$];
  out_item_t expected_records[$];

  // Predictor state: the profiler's registers and stores as the bench sees them.
  logic                prof_on;
  logic [STAMP_W-1:0]  close_limit;
  logic [CNT_W-1:0]    blk_runs [NB];
  logic [STAMP_W-1:0]  blk_stamp [NB];
  logic [STAMP_W-1:0]  region_insts;
  logic [STAMP_W-1:0]  total_insts;
  logic [31:0]         region_seq;

  // Bookkeeping for the closing summary and the verdict.
  int unsigned fault_count   = 0;
  int unsigned n_transfers   = 0;
  int unsigned n_records     = 0;
  int unsigned n_limit_close = 0;
  int unsigned n_end_close   = 0;
  int unsigned widest_close  = 0;
  int unsigned cycle_n       = 0;

  // Generator state, only used while the stimulus is being built.
  logic        gen_on = 1'b0;
  logic        burst  = 1'b0;
  int unsigned live_items = 0;

  // Driver state.
  drv_state_e  dstate   = D_FETCH;
  int unsigned gap_left = 0;
  action_t     cur_op;
  logic        drv_done = 1'b0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [STAMP_W-1:0] sat_add48(input logic [STAMP_W-1:0] a,
                                                   input logic [STAMP_W-1:0] b);
    logic [STAMP_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[STAMP_W] ? LIMIT_MAX : s[STAMP_W-1:0];
  endfunction

  task automatic reset_profile();
    prof_on      = 1'b0;
    close_limit  = LIMIT_RESET;
    region_insts = '0;
    total_insts  = '0;
    region_seq   = '0;
    for (int b = 0; b < NB; b++) begin
      blk_runs[b]  = '0;
      blk_stamp[b] = '0;
    end
  endtask

  // Closing a region lists every block that ran, lowest index first, then
  // the summary; the stores and the region count start afresh afterwards.
  task automatic close_region(input logic at_end);
    out_item_t   r;
    int unsigned n;
    n = 0;
    for (int b = 0; b < NB; b++) begin
      if (blk_runs[b] != '0 && n < 32) begin
        r                     = '0;
        r.kind                = KIND_ENTRY;
        r.region_number       = region_seq;
        r.entry_block         = b[4:0];
        r.exec_count          = blk_runs[b];
        r.last_stamp          = blk_stamp[b];
        expected_records.push_back(r);
        n++;
      end
    end
    total_insts           = sat_add48(total_insts, region_insts);
    r                     = '0;
    r.kind                = KIND_SUMMARY;
    r.region_number       = region_seq;
    r.region_instructions = region_insts;
    r.total_instructions  = total_insts;
    r.last                = at_end;
    expected_records.push_back(r);
    n++;
    if (n > widest_close) widest_close = n;
    if (at_end) n_end_close++;
    else n_limit_close++;
    region_seq   = region_seq + 32'd1;
    region_insts = '0;
    for (int b = 0; b < NB; b++) begin
      blk_runs[b]  = '0;
      blk_stamp[b] = '0;
    end
  endtask

  task automatic predict_profile(input in_item_t it);
    int unsigned b;
    b = 32'(it.block_index);
    if (it.operation == OP_END) begin
      prof_on = 1'b0;
      close_region(1'b1);
    end else if (prof_on && b < NB) begin
      region_insts = sat_add48(region_insts, {32'd0, it.block_instructions});
      if (blk_runs[b] != '1) blk_runs[b] = blk_runs[b] + 32'd1;
      blk_stamp[b] = region_insts;
      if (region_insts > close_limit) close_region(1'b0);
    end
  endtask

  task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    if (idx == CFG_ENABLE) prof_on = data[0];
    else if (idx == CFG_LIMIT) close_limit = data[STAMP_W-1:0];
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------

  function automatic logic [47:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  // Instruction counts lean on the two extremes now and then.
  function automatic logic [15:0] rand_insts();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return w[15:0];
    endcase
  endfunction

  // Small limits close a region every event or two, middling ones let
  // counts and stamps build up, and the widest ones only close on an end
  // of interest.
  function automatic logic [47:0] pick_limit();
    case ($urandom_range(0, 9))
      0:          return '0;
      1:          return LIMIT_MAX;
      2:          return rand48();
      3, 4, 5:    return 48'($urandom_range(1000, 60000));
      default:    return 48'($urandom_range(60000, 600000));
    endcase
  endfunction

  // Only events that the block will act upon count towards the wanted total.
  task automatic add_item(input logic op, input logic [15:0] insts,
                          input logic [4:0] blk);
    action_t a;
    a.kind                    = ACT_ITEM;
    a.item.operation          = op;
    a.item.block_instructions = insts;
    a.item.block_index        = blk;
    a.idx                     = '0;
    a.data                    = '0;
    a.gap                     = burst ? 0 : $urandom_range(0, MAX_GAP);
    if (op == OP_END || gen_on) live_items++;
    if (op == OP_END) gen_on = 1'b0;
    pending_ops.push_back(a);
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx,
                         input logic [CFG_DATA_W-1:0] data);
    action_t a;
    a.kind = ACT_CFG;
    a.item = '0;
    a.idx  = idx;
    a.data = data;
    a.gap  = 0;
    if (idx == CFG_ENABLE) gen_on = data[0];
    pending_ops.push_back(a);
  endtask

  task automatic add_hold();
    action_t a;
    a.kind = ACT_HOLD;
    a.item = '0;
    a.idx  = '0;
    a.data = '0;
    a.gap  = 0;
    pending_ops.push_back(a);
  endtask

  task automatic add_random_event(input logic narrow, input int unsigned base);
    logic [31:0] w;
    w = $urandom;
    if (narrow) add_item(OP_BLOCK, rand_insts(), 5'(base + $urandom_range(0, 3)));
    else add_item(OP_BLOCK, rand_insts(), w[4:0]);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: works through the queue one step at a time on rising edges. A new
  // event follows a transfer without start dropping when its gap is zero.
  // ---------------------------------------------------------------------------

  task take_next();
    if (pending_ops.size() == 0) begin
      start    <= 1'b0;
      drv_done <= 1'b1;
      dstate   <= D_DONE;
    end else begin
      cur_op = pending_ops.pop_front();
      if (cur_op.kind == ACT_ITEM && cur_op.gap == 0) begin
        start   <= 1'b1;
        in_data <= cur_op.item;
        dstate  <= D_ITEM;
      end else begin
        start    <= 1'b0;
        gap_left <= cur_op.gap;
        dstate   <= (cur_op.kind == ACT_ITEM) ? D_GAP : D_DRAIN;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start     <= 1'b0;
      cfg_valid <= 1'b0;
      dstate    <= D_FETCH;
    end else begin
      case (dstate)
        D_FETCH: begin
          take_next();
        end
        D_GAP: begin
          if (gap_left <= 1) begin
            start   <= 1'b1;
            in_data <= cur_op.item;
            dstate  <= D_ITEM;
          end else begin
            gap_left <= gap_left - 1;
          end
        end
        D_ITEM: begin
          // Start is high here; the transfer happens once busy is low.
          if (!busy) begin
            n_transfers++;
            predict_profile(cur_op.item);
            take_next();
          end
        end
        D_DRAIN: begin
          // Registers change and pauses end only once the block has
          // delivered everything that it owes.
          if (expected_records.size() == 0) begin
            gap_left <= HOLD_OFF;
            dstate   <= D_HOLD;
          end
        end
        D_HOLD: begin
          if (gap_left == 0) begin
            if (cur_op.kind == ACT_CFG) begin
              cfg_valid <= 1'b1;
              cfg_index <= cur_op.idx;
              cfg_data  <= cur_op.data;
              dstate    <= D_CFG;
            end else begin
              take_next();
            end
          end else begin
            gap_left <= gap_left - 1;
          end
        end
        D_CFG: begin
          if (cfg_ready) begin
            apply_register(cur_op.idx, cur_op.data);
            cfg_valid <= 1'b0;
            take_next();
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobed record is a transfer that must match the oldest
  // expected record field by field.
  // ---------------------------------------------------------------------------

  function automatic string render(input out_item_t r);
    return $sformatf("kind=%0d region=%0d blk=%0d cnt=%0d stamp=%h rinst=%h tot=%h last=%0d",
                     r.kind, r.region_number, r.entry_block, r.exec_count,
                     r.last_stamp, r.region_instructions, r.total_instructions,
                     r.last);
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_strobe) begin
      n_records++;
      if (expected_records.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_MAX)
          $display("[%0t] record with none expected: %s", $realtime, render(out_data));
      end else begin
        want = expected_records.pop_front();
        if (out_data.kind                !== want.kind                ||
            out_data.region_number       !== want.region_number       ||
            out_data.entry_block         !== want.entry_block         ||
            out_data.exec_count          !== want.exec_count          ||
            out_data.last_stamp          !== want.last_stamp          ||
            out_data.region_instructions !== want.region_instructions ||
            out_data.total_instructions  !== want.total_instructions  ||
            out_data.last                !== want.last) begin
          fault_count++;
          if (fault_count <= REPORT_MAX) begin
            $display("[%0t] record mismatch", $realtime);
            $display("  expected: %s", render(want));
            $display("  actual:   %s", render(out_data));
          end
        end
      end
    end
  end

  // A stuck handshake or a lost record ends the run here.
  always @(posedge clk) begin
    cycle_n++;
    if (cycle_n > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d records outstanding", cycle_n,
               expected_records.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus plan, reset and verdict
  // ---------------------------------------------------------------------------

  initial begin : main
    logic        narrow;
    int unsigned base;
    int unsigned n;

    reset_profile();

    // Straight after reset profiling is off: events are ignored, yet an end
    // of interest still closes the empty region with a summary.
    burst = 1'b0;
    add_item(OP_BLOCK, 16'hFFFF, 5'd31);
    add_item(OP_BLOCK, 16'h0000, 5'd0);
    add_item(OP_END, rand_insts(), 5'd17);

    // Undecoded indexes, then an enable write whose bit zero is clear, so the
    // event that follows is still ignored.
    add_cfg(CFG_SPARE_IDX, rand48());
    add_cfg(CFG_TOP_IDX, LIMIT_MAX);
    add_cfg(CFG_ENABLE, {47'(rand48() >> 1), 1'b0});
    add_item(OP_BLOCK, 16'h1234, 5'd9);

    // A zero limit: an empty event leaves the count at the limit, any other
    // closes the region at once.
    add_cfg(CFG_LIMIT, '0);
    add_cfg(CFG_ENABLE, {47'(rand48() >> 1), 1'b1});
    add_item(OP_BLOCK, 16'h0000, 5'd0);
    add_item(OP_BLOCK, 16'hFFFF, 5'd31);
    add_item(OP_BLOCK, 16'h0001, 5'd5);

    // The widest limit never closes on its own; the end of interest lists
    // the blocks, clears the enable and the next event is ignored.
    add_cfg(CFG_LIMIT, LIMIT_MAX);
    add_item(OP_BLOCK, 16'h1234, 5'd3);
    add_item(OP_BLOCK, 16'h1234, 5'd3);
    add_item(OP_BLOCK, 16'hFFFF, 5'd31);
    add_item(OP_BLOCK, 16'h0000, 5'd0);
    add_item(OP_END, rand_insts(), 5'd0);
    add_item(OP_BLOCK, 16'h00FF, 5'd1);

    // Reaching the limit exactly keeps the region open; one more closes it.
    add_cfg(CFG_LIMIT, 48'd100);
    add_cfg(CFG_ENABLE, 48'd1);
    add_item(OP_BLOCK, 16'd100, 5'd12);
    add_hold();
    add_item(OP_BLOCK, 16'd1, 5'd30);

    // Random phases: each sets a limit, turns profiling on and sends a run
    // of events, now spread over all blocks, now crowded onto a few.
    live_items = 0;
    while (live_items < ITEMS_WANTED) begin
      burst = ($urandom_range(0, 3) == 0);
      add_cfg(CFG_LIMIT, pick_limit());
      if ($urandom_range(0, 7) == 0) begin
        add_cfg(CFG_ENABLE, {47'(rand48() >> 1), 1'b0});
        repeat (4) add_random_event(1'b0, 0);
      end
      add_cfg(CFG_ENABLE, {47'(rand48() >> 1), 1'b1});
      narrow = ($urandom_range(0, 2) == 0);
      base   = $urandom_range(0, NB - 4);
      n      = $urandom_range(8, 40);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 39) == 0) begin
          add_item(OP_END, rand_insts(), 5'($urandom_range(0, 31)));
          add_cfg(CFG_ENABLE, 48'd1);
        end else begin
          add_random_event(narrow, base);
        end
      end
      if ($urandom_range(0, 1) == 0) add_item(OP_END, rand_insts(), 5'($urandom_range(0, 31)));
    end

    // Reset is held from time zero and released once.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the last transfer and every owed record, then a quiet spell
    // in case anything further turns up.
    while (!(drv_done && expected_records.size() == 0)) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);

    $display("Run covered %0d transfers in and %0d records out over %0d region closes",
             n_transfers, n_records, n_limit_close + n_end_close);
    $display("(%0d on the limit, %0d on end of interest), the largest close giving %0d records",
             n_limit_close, n_end_close, widest_close);
    if (fault_count == 0 && expected_records.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Failures: %0d, records still owed: %0d", fault_count,
               expected_records.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
